// ===== src/sgen_pkg.sv =====
// Package for the four-channel sound generator: register indexes, bus codes,
// address tables, the full state record and its power-on value.
// No dependencies.
`timescale 1ns / 1ps

package sgen_pkg;

  localparam int unsigned NumRegs = 21;

  localparam logic [4:0] R10 = 5'd0;
  localparam logic [4:0] R11 = 5'd1;
  localparam logic [4:0] R12 = 5'd2;
  localparam logic [4:0] R13 = 5'd3;
  localparam logic [4:0] R14 = 5'd4;
  localparam logic [4:0] R21 = 5'd5;
  localparam logic [4:0] R22 = 5'd6;
  localparam logic [4:0] R23 = 5'd7;
  localparam logic [4:0] R24 = 5'd8;
  localparam logic [4:0] R30 = 5'd9;
  localparam logic [4:0] R31 = 5'd10;
  localparam logic [4:0] R32 = 5'd11;
  localparam logic [4:0] R33 = 5'd12;
  localparam logic [4:0] R34 = 5'd13;
  localparam logic [4:0] R41 = 5'd14;
  localparam logic [4:0] R42 = 5'd15;
  localparam logic [4:0] R43 = 5'd16;
  localparam logic [4:0] R44 = 5'd17;
  localparam logic [4:0] R50 = 5'd18;
  localparam logic [4:0] R51 = 5'd19;
  localparam logic [4:0] R52 = 5'd20;
  localparam logic [4:0] NoReg = 5'd31;

  localparam logic [1:0] CmdNone  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  localparam logic [1:0] PhaseAudio = 2'd0;
  localparam logic [1:0] PhaseWrite = 2'd2;

  localparam logic [15:0] AddrFirst  = 16'hFF10;
  localparam logic [15:0] AddrStatus = 16'hFF26;
  localparam logic [15:0] AddrWave   = 16'hFF30;
  localparam logic [15:0] AddrLast   = 16'hFF3F;
  localparam logic [15:0] AddrNr12   = 16'hFF12;
  localparam logic [15:0] AddrNr14   = 16'hFF14;
  localparam logic [15:0] AddrNr22   = 16'hFF17;
  localparam logic [15:0] AddrNr24   = 16'hFF19;
  localparam logic [15:0] AddrNr34   = 16'hFF1E;
  localparam logic [15:0] AddrNr42   = 16'hFF21;
  localparam logic [15:0] AddrNr44   = 16'hFF23;

  typedef struct packed {
    logic [NumRegs-1:0][7:0] regs;
    logic [15:0][7:0]        wave;
    logic [13:0]             fclk;
    logic [3:0]              en;
    logic [2:0]              swt;
    logic [10:0]             swf;
    logic [3:0][8:0]         len;
    logic [2:0][3:0]         lvl;
    logic [2:0][2:0]         etm;
    logic [3:0][10:0]        per;
    logic [1:0][2:0]         duty;
    logic [4:0]              wpos;
    logic [14:0]             lfsr;
    logic                    rv;
    logic [7:0]              rd;
    logic [8:0]              mr;
    logic [8:0]              ml;
  } sgen_st_t;

  function automatic logic [4:0] addr_reg(input logic [4:0] off);
    unique case (off)
      5'd0: addr_reg = R10;   5'd1: addr_reg = R11;   5'd2: addr_reg = R12;
      5'd3: addr_reg = R13;   5'd4: addr_reg = R14;   5'd6: addr_reg = R21;
      5'd7: addr_reg = R22;   5'd8: addr_reg = R23;   5'd9: addr_reg = R24;
      5'd10: addr_reg = R30;  5'd11: addr_reg = R31;  5'd12: addr_reg = R32;
      5'd13: addr_reg = R33;  5'd14: addr_reg = R34;  5'd16: addr_reg = R41;
      5'd17: addr_reg = R42;  5'd18: addr_reg = R43;  5'd19: addr_reg = R44;
      5'd20: addr_reg = R50;  5'd21: addr_reg = R51;  5'd22: addr_reg = R52;
      default: addr_reg = NoReg;
    endcase
  endfunction

  function automatic logic [7:0] read_mask(input logic [4:0] off);
    unique case (off)
      5'd0: read_mask = 8'h80;  5'd1: read_mask = 8'h3F;  5'd4: read_mask = 8'hBF;
      5'd6: read_mask = 8'h3F;  5'd9: read_mask = 8'hBF;  5'd10: read_mask = 8'h7F;
      5'd12: read_mask = 8'h9F; 5'd14: read_mask = 8'hBF; 5'd19: read_mask = 8'hBF;
      5'd3, 5'd5, 5'd8, 5'd11, 5'd13, 5'd15, 5'd16: read_mask = 8'hFF;
      default: read_mask = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] write_mask(input logic [4:0] off);
    unique case (off)
      5'd0: write_mask = 8'h80;  5'd4: write_mask = 8'h38;  5'd9: write_mask = 8'h38;
      5'd10: write_mask = 8'h7F; 5'd12: write_mask = 8'h9F; 5'd14: write_mask = 8'h38;
      5'd16: write_mask = 8'hC0; 5'd19: write_mask = 8'h3F; 5'd22: write_mask = 8'h70;
      default: write_mask = 8'h00;
    endcase
  endfunction

  function automatic sgen_st_t st_reset();
    sgen_st_t s;
    s = '0;
    s.regs[R10] = 8'h80; s.regs[R11] = 8'hBF; s.regs[R12] = 8'hF3;
    s.regs[R13] = 8'hFF; s.regs[R14] = 8'hBF; s.regs[R21] = 8'h3F;
    s.regs[R22] = 8'h00; s.regs[R23] = 8'hFF; s.regs[R24] = 8'hBF;
    s.regs[R30] = 8'h7F; s.regs[R31] = 8'hFF; s.regs[R32] = 8'h9F;
    s.regs[R33] = 8'hFF; s.regs[R34] = 8'hBF; s.regs[R41] = 8'hFF;
    s.regs[R42] = 8'h00; s.regs[R43] = 8'h00; s.regs[R44] = 8'hBF;
    s.regs[R50] = 8'h77; s.regs[R51] = 8'hF3; s.regs[R52] = 8'hF1;
    s.en = 4'b0001;
    s.lfsr = 15'h7FFF;
    return s;
  endfunction

endpackage

// ===== src/sgen_if.sv =====
// Handshake channels of the sound generator: bus item in, result item out.
// No dependencies.
`timescale 1ns / 1ps

interface sgen_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, phase, command, address, write_data, input ready);
  modport sink (input valid, phase, command, address, write_data, output ready);
endinterface

interface sgen_out_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_data;
  logic [8:0] mix_right;
  logic [8:0] mix_left;
  modport source (output valid, reply_valid, reply_data, mix_right, mix_left, input ready);
  modport sink (input valid, reply_valid, reply_data, mix_right, mix_left, output ready);
endinterface

// ===== src/sgen_bus.sv =====
// Bus side of the sound generator: phase-0 reads, phase-2 writes, envelope
// glitches, channel triggers and power control. Depends on sgen_pkg.
`timescale 1ns / 1ps

module sgen_bus import sgen_pkg::*; (
  input  sgen_st_t    st_i,
  input  logic [1:0]  phase_i,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output sgen_st_t    st_o
);

  logic [7:0]  off8;
  logic [4:0]  off;
  logic [4:0]  ridx;
  logic        in_regs;
  logic        in_wave;
  logic        on;
  logic [10:0] f1;
  logic [10:0] f2;
  logic [10:0] f3;
  logic [7:0]  nrx2;
  logic [3:0]  npr;

  assign off8    = address_i[7:0] - 8'h10;
  assign off     = off8[4:0];
  assign ridx    = addr_reg(off);
  assign in_regs = (address_i >= AddrFirst) && (address_i <= AddrStatus);
  assign in_wave = (address_i >= AddrWave) && (address_i <= AddrLast);
  assign on      = st_i.regs[R52][7];

  always_comb begin
    st_o = st_i;
    f1   = '0;
    f2   = '0;
    f3   = '0;
    nrx2 = '0;
    npr  = '0;
    if (phase_i == PhaseAudio && command_i == CmdRead) begin
      st_o.rv = 1'b0;
      st_o.rd = '0;
      if (in_regs) begin
        st_o.rv = 1'b1;
        if (address_i == AddrStatus) begin
          st_o.rd = {st_i.regs[R52][7], 3'b111, st_i.en};
        end else if (ridx == NoReg) begin
          st_o.rd = 8'hFF;
        end else begin
          st_o.rd = st_i.regs[ridx] | read_mask(off);
        end
      end else if (in_wave) begin
        st_o.rv = 1'b1;
        st_o.rd = st_i.wave[address_i[3:0]];
      end
    end
    if (phase_i == PhaseWrite && command_i == CmdWrite && (in_regs || in_wave ||
        (address_i > AddrStatus && address_i < AddrWave))) begin
      if (!on) begin
        if (address_i == AddrStatus) begin
          st_o.regs[R52] = write_data_i | 8'h70;
          if (write_data_i[7]) begin
            st_o = st_reset();
          end
        end
      end else begin
        if (address_i == AddrNr12) begin
          if (st_i.regs[R12][3] && st_i.en[0]) st_o.lvl[0] = st_i.lvl[0] + 4'd1;
          if ((write_data_i & 8'hF8) == 8'h00) st_o.en[0] = 1'b0;
        end
        if (address_i == AddrNr22) begin
          if (st_i.regs[R22][3] && st_i.en[1]) st_o.lvl[1] = st_i.lvl[1] + 4'd1;
          if ((write_data_i & 8'hF8) == 8'h00) st_o.en[1] = 1'b0;
        end
        if (address_i == AddrNr42) begin
          if (st_i.regs[R42][3] && st_i.en[3]) st_o.lvl[2] = st_i.lvl[2] + 4'd1;
          if ((write_data_i & 8'hF8) == 8'h00) st_o.en[3] = 1'b0;
        end
        if (in_regs && ridx != NoReg) begin
          st_o.regs[ridx] = write_data_i | write_mask(off);
        end
        if (in_wave) begin
          st_o.wave[address_i[3:0]] = write_data_i;
        end
        f1 = {st_o.regs[R14][2:0], st_o.regs[R13]};
        f2 = {st_o.regs[R24][2:0], st_o.regs[R23]};
        f3 = {st_o.regs[R34][2:0], st_o.regs[R33]};
        if (write_data_i[7]) begin
          if (address_i == AddrNr14) begin
            nrx2 = st_o.regs[R12];
            st_o.en[0]   = (nrx2 & 8'hF8) != 8'h00;
            st_o.lvl[0]  = nrx2[3] ? nrx2[7:4] : ~nrx2[7:4];
            st_o.etm[0]  = nrx2[2:0];
            st_o.len[0]  = 9'd64 - {3'b000, st_o.regs[R11][5:0]};
            st_o.swt     = st_o.regs[R10][6:4];
            st_o.swf     = f1;
            st_o.per[0]  = ~f1;
            st_o.duty[0] = '0;
          end else if (address_i == AddrNr24) begin
            nrx2 = st_o.regs[R22];
            st_o.en[1]   = (nrx2 & 8'hF8) != 8'h00;
            st_o.lvl[1]  = nrx2[3] ? nrx2[7:4] : ~nrx2[7:4];
            st_o.etm[1]  = nrx2[2:0];
            st_o.len[1]  = 9'd64 - {3'b000, st_o.regs[R21][5:0]};
            st_o.per[1]  = ~f2;
            st_o.duty[1] = '0;
          end else if (address_i == AddrNr34) begin
            st_o.en[2]  = st_o.regs[R32] != 8'h00;
            st_o.len[2] = 9'd256 - {1'b0, st_o.regs[R31]};
            st_o.per[2] = ~f3;
            st_o.wpos   = '0;
          end else if (address_i == AddrNr44) begin
            nrx2 = st_o.regs[R42];
            npr  = (st_o.regs[R43][2:0] != 3'd0) ? {st_o.regs[R43][2:0], 1'b0} : 4'd1;
            st_o.en[3]  = (nrx2 & 8'hF8) != 8'h00;
            st_o.lvl[2] = nrx2[3] ? nrx2[7:4] : ~nrx2[7:4];
            st_o.etm[2] = nrx2[2:0];
            st_o.len[3] = 9'd64 - {3'b000, st_o.regs[R41][5:0]};
            st_o.per[3] = {7'd0, npr};
            st_o.lfsr   = 15'h7FFF;
          end
        end
      end
    end
  end

endmodule

// ===== src/sgen_audio.sv =====
// Audio side of the sound generator: frame clock, sweep, length, envelope,
// the four channel generators and the per-side mix. Depends on sgen_pkg.
`timescale 1ns / 1ps

module sgen_audio import sgen_pkg::*; (
  input  sgen_st_t   st_i,
  input  logic [1:0] phase_i,
  input  logic       on_i,
  output sgen_st_t   st_o
);

  logic [13:0] nclk;
  logic [15:0] flip;
  logic [11:0] nf;
  logic [10:0] delta;
  logic [10:0] f1;
  logic [3:0]  npr;
  logic        fb;
  logic [3:0]  vol [3];
  logic [2:0]  thr [2];
  logic [3:0]  o1, o2, o3, o4, wnib;
  logic [7:0]  wbyte;
  logic [5:0]  mr, ml;
  logic [7:0]  ctl [4];
  logic [7:0]  env_reg [3];

  assign nclk = st_i.fclk + 14'd1;
  assign flip = {2'b00, ~st_i.fclk & nclk};

  always_comb begin
    st_o       = st_i;
    nf         = '0;
    delta      = '0;
    f1         = '0;
    npr        = '0;
    fb         = 1'b0;
    o1         = '0;
    o2         = '0;
    o3         = '0;
    o4         = '0;
    wbyte      = '0;
    wnib       = '0;
    mr         = '0;
    ml         = '0;
    ctl[0]     = st_i.regs[R14];
    ctl[1]     = st_i.regs[R24];
    ctl[2]     = st_i.regs[R34];
    ctl[3]     = st_i.regs[R44];
    env_reg[0] = st_i.regs[R12];
    env_reg[1] = st_i.regs[R22];
    env_reg[2] = st_i.regs[R42];
    for (int k = 0; k < 3; k++) begin
      vol[k] = '0;
    end
    for (int k = 0; k < 2; k++) begin
      thr[k] = '0;
    end
    if (phase_i == PhaseAudio) begin
      if (!on_i) begin
        st_o.mr = '0;
        st_o.ml = '0;
      end else begin
        st_o.fclk = nclk;
        if (nclk[12:0] == 13'h1000 && st_i.regs[R10][6:4] != 3'd0 &&
            st_i.regs[R10][2:0] != 3'd0) begin
          if (st_i.swt != 3'd0) begin
            st_o.swt = st_i.swt - 3'd1;
          end else begin
            delta = st_i.swf >> st_i.regs[R10][2:0];
            nf = st_i.regs[R10][3] ? {1'b0, st_i.swf} - {1'b0, delta}
                                   : {1'b0, st_i.swf} + {1'b0, delta};
            st_o.swt = st_i.regs[R10][6:4];
            if (nf[11]) st_o.en[0] = 1'b0;
            else st_o.swf = nf[10:0];
          end
        end
        if (nclk[11:0] == 12'h000) begin
          for (int i = 0; i < 4; i++) begin
            if (ctl[i][6] && st_i.len[i] != 9'd0) st_o.len[i] = st_i.len[i] - 9'd1;
            if (ctl[i][6] && st_o.len[i] == 9'd0) st_o.en[i] = 1'b0;
          end
        end
        if (nclk == 14'h3800) begin
          for (int k = 0; k < 3; k++) begin
            if (env_reg[k][2:0] != 3'd0) begin
              if (st_i.etm[k] != 3'd0) begin
                st_o.etm[k] = st_i.etm[k] - 3'd1;
              end else begin
                st_o.etm[k] = env_reg[k][2:0];
                if (st_i.lvl[k] != 4'hF) st_o.lvl[k] = st_i.lvl[k] + 4'd1;
              end
            end
          end
        end
        f1 = (st_i.regs[R10][6:4] != 3'd0) ? st_o.swf : {st_i.regs[R14][2:0], st_i.regs[R13]};
        if (st_i.per[0] == 11'd0) begin
          st_o.per[0]  = ~f1;
          st_o.duty[0] = st_i.duty[0] + 3'd1;
        end else begin
          st_o.per[0] = st_i.per[0] - 11'd1;
        end
        if (st_i.per[1] == 11'd0) begin
          st_o.per[1]  = ~{st_i.regs[R24][2:0], st_i.regs[R23]};
          st_o.duty[1] = st_i.duty[1] + 3'd1;
        end else begin
          st_o.per[1] = st_i.per[1] - 11'd1;
        end
        for (int j = 0; j < 2; j++) begin
          if (st_o.per[2] == 11'd0) begin
            st_o.per[2] = ~{st_i.regs[R34][2:0], st_i.regs[R33]};
            st_o.wpos   = st_o.wpos + 5'd1;
          end else begin
            st_o.per[2] = st_o.per[2] - 11'd1;
          end
        end
        npr = (st_i.regs[R43][2:0] != 3'd0) ? {st_i.regs[R43][2:0], 1'b0} : 4'd1;
        if (st_i.per[3] == 11'd0) begin
          fb = st_i.lfsr[0] ^ st_i.lfsr[1];
          st_o.per[3] = {7'd0, npr};
          st_o.lfsr = {fb, st_i.lfsr[14:1]};
          if (st_i.regs[R43][3]) st_o.lfsr[6] = fb;
        end else begin
          st_o.per[3] = st_i.per[3] - {10'd0, flip[st_i.regs[R43][7:4]]};
        end
        vol[0] = st_i.regs[R12][3] ? st_o.lvl[0] : ~st_o.lvl[0];
        vol[1] = st_i.regs[R22][3] ? st_o.lvl[1] : ~st_o.lvl[1];
        vol[2] = st_i.regs[R42][3] ? st_o.lvl[2] : ~st_o.lvl[2];
        thr[0] = (st_i.regs[R11][7:6] != 2'd0) ? {st_i.regs[R11][7:6], 1'b0} : 3'd1;
        thr[1] = (st_i.regs[R21][7:6] != 2'd0) ? {st_i.regs[R21][7:6], 1'b0} : 3'd1;
        if (st_o.en[0] && st_o.duty[0] < thr[0]) o1 = vol[0];
        if (st_o.en[1] && st_o.duty[1] < thr[1]) o2 = vol[1];
        if (st_o.en[2] && st_i.regs[R30][7]) begin
          wbyte = st_i.wave[st_o.wpos[4:1]];
          wnib  = st_o.wpos[0] ? wbyte[3:0] : wbyte[7:4];
          unique case (st_i.regs[R32][6:5])
            2'd0: o3 = 4'd0;
            2'd1: o3 = wnib;
            2'd2: o3 = wnib >> 1;
            2'd3: o3 = wnib >> 2;
          endcase
        end
        if (st_o.en[3] && st_o.lfsr[0]) o4 = vol[2];
        if (st_i.regs[R51][0]) mr = mr + {2'b00, o1};
        if (st_i.regs[R51][1]) mr = mr + {2'b00, o2};
        if (st_i.regs[R51][2]) mr = mr + {2'b00, o3};
        if (st_i.regs[R51][3]) mr = mr + {2'b00, o4};
        if (st_i.regs[R51][4]) ml = ml + {2'b00, o1};
        if (st_i.regs[R51][5]) ml = ml + {2'b00, o2};
        if (st_i.regs[R51][6]) ml = ml + {2'b00, o3};
        if (st_i.regs[R51][7]) ml = ml + {2'b00, o4};
        st_o.mr = 9'({3'b000, mr} * ({6'd0, st_i.regs[R50][2:0]} + 9'd1));
        st_o.ml = 9'({3'b000, ml} * ({6'd0, st_i.regs[R50][6:4]} + 9'd1));
      end
    end
  end

endmodule

// ===== src/four_channel_sound_generator.sv =====
// Top level of the four-channel sound generator: state register, handshake
// and result hold. Depends on sgen_pkg, sgen_if, sgen_bus and sgen_audio.
//
//   channel   direction  carries
//   in_i      sink       phase, command, address, write_data
//   out_o     source     reply_valid, reply_data, mix_right, mix_left
//
// Each transfer on in_i is processed combinationally; its result is held in the
// state register and offered on out_o from the next cycle.
// A new item is taken in every cycle in which out_o is empty or being taken.
// A stalled result holds its value and blocks the input until taken.
// Reset loads the power-on register values, enables channel one only, fills
// the noise shift register with ones and clears all other state.
`timescale 1ns / 1ps

module four_channel_sound_generator import sgen_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgen_in_if.sink    in_i,
  sgen_out_if.source out_o
);

  sgen_st_t st_q, st_d, st_bus;
  logic     out_valid_q, out_valid_d;
  logic     accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  sgen_bus u_bus (
    .st_i         (st_q),
    .phase_i      (in_i.phase),
    .command_i    (in_i.command),
    .address_i    (in_i.address),
    .write_data_i (in_i.write_data),
    .st_o         (st_bus)
  );

  sgen_audio u_audio (
    .st_i    (st_bus),
    .phase_i (in_i.phase),
    .on_i    (st_q.regs[R52][7]),
    .st_o    (st_d)
  );

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= st_reset();
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) st_q <= st_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.reply_valid = st_q.rv;
  assign out_o.reply_data  = st_q.rd;
  assign out_o.mix_right   = st_q.mr;
  assign out_o.mix_left    = st_q.ml;

`ifndef SYNTHESIS
  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.rv |-> st_q.rd == 8'h00) else $error("reply data set without valid");
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted item gave no result");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready) else $error("input taken while stalled");
  a_off_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !st_q.regs[R52][7] && in_i.phase == PhaseAudio) |=>
    (st_q.mr == 9'd0 && st_q.ml == 9'd0)) else $error("mix not silent with power off");
`endif

endmodule

// ===== sim/tb_four_channel_sound_generator.sv =====
// Self-checking testbench for the four-channel sound generator: drives bus
// items through the input channel and checks every result against a predictor.
// Depends on sgen_pkg, sgen_if and four_channel_sound_generator.
`timescale 1ns / 1ps

module tb_four_channel_sound_generator;
  import sgen_pkg::*;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_data;
    logic [8:0] mix_right;
    logic [8:0] mix_left;
  } sound_out_t;

  typedef struct {
    bus_item_t  item;
    logic       known;
    sound_out_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  sgen_in_if  in_ch ();
  sgen_out_if out_ch ();

  four_channel_sound_generator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Predictor state.
  logic [7:0]  snd_reg [NumRegs];
  logic [7:0]  wave_mem [16];
  logic [13:0] frame_cnt;
  logic [3:0]  chan_on;
  logic [2:0]  sweep_cnt;
  logic [10:0] sweep_freq;
  logic [8:0]  len_cnt [4];
  logic [3:0]  env_lvl [3];
  logic [2:0]  env_cnt [3];
  logic [10:0] period_cnt [4];
  logic [2:0]  duty_pos [2];
  logic [4:0]  wave_pos;
  logic [14:0] lfsr;
  logic        held_valid;
  logic [7:0]  held_data;
  logic [8:0]  held_right;
  logic [8:0]  held_left;

  sound_out_t expected_q [$];
  logic       known_q [$];
  sound_out_t known_want_q [$];
  int         mismatches;
  int         results_seen;
  int         items_sent;
  bit         stim_done;
  bit         long_hold;

  function automatic logic [4:0] reg_of(input logic [15:0] a);
    case (a - AddrFirst)
      0: return R10;  1: return R11;  2: return R12;  3: return R13;  4: return R14;
      6: return R21;  7: return R22;  8: return R23;  9: return R24;
      10: return R30; 11: return R31; 12: return R32; 13: return R33; 14: return R34;
      16: return R41; 17: return R42; 18: return R43; 19: return R44;
      20: return R50; 21: return R51; 22: return R52;
      default: return NoReg;
    endcase
  endfunction

  function automatic logic [7:0] rd_mask(input logic [15:0] a);
    case (a - AddrFirst)
      0: return 8'h80;  1: return 8'h3F;  4: return 8'hBF;  6: return 8'h3F;
      9: return 8'hBF;  10: return 8'h7F; 12: return 8'h9F; 14: return 8'hBF;
      19: return 8'hBF;
      3, 5, 8, 11, 13, 15, 16: return 8'hFF;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] wr_mask(input logic [15:0] a);
    case (a - AddrFirst)
      0: return 8'h80;  4: return 8'h38;  9: return 8'h38;  10: return 8'h7F;
      12: return 8'h9F; 14: return 8'h38; 16: return 8'hC0; 19: return 8'h3F;
      22: return 8'h70;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [10:0] freq_word(input logic [4:0] hi, input logic [4:0] lo);
    return {snd_reg[hi][2:0], snd_reg[lo]};
  endfunction

  function automatic logic [10:0] noise_div();
    return (snd_reg[R43][2:0] == 0) ? 11'd1 : {7'd0, snd_reg[R43][2:0], 1'b0};
  endfunction

  function automatic logic [3:0] env_vol(input int k, input logic [7:0] nrx2);
    return nrx2[3] ? env_lvl[k] : (4'hF ^ env_lvl[k]);
  endfunction

  function automatic logic [3:0] duty_out(input int k, input logic [7:0] nrx1,
                                           input logic [3:0] vol);
    logic [3:0] d;
    d = (nrx1[7:6] == 0) ? 4'd1 : {1'b0, nrx1[7:6], 1'b0};
    return ({1'b0, duty_pos[k]} < d) ? vol : 4'd0;
  endfunction

  task automatic sound_reset();
    logic [7:0] init [NumRegs];
    init = '{8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'h7F,
             8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1};
    snd_reg = init;
    for (int i = 0; i < 16; i++) wave_mem[i] = 8'h00;
    frame_cnt = '0;
    chan_on = 4'b0001;
    sweep_cnt = '0;
    sweep_freq = '0;
    for (int i = 0; i < 4; i++) begin
      len_cnt[i] = '0;
      period_cnt[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      env_lvl[i] = '0;
      env_cnt[i] = '0;
    end
    duty_pos[0] = '0;
    duty_pos[1] = '0;
    wave_pos = '0;
    lfsr = 15'h7FFF;
    held_valid = 1'b0;
    held_data = '0;
    held_right = '0;
    held_left = '0;
  endtask

  task automatic env_write_glitch(input int k, input logic [3:0] bitm, input logic [7:0] nrx2,
                                  input logic [7:0] d);
    if (nrx2[3] && (chan_on & bitm) != 0) env_lvl[k] = env_lvl[k] + 4'd1;
    if ((d & 8'hF8) == 0) chan_on &= ~bitm;
  endtask

  task automatic env_start(input int k, input logic [3:0] bitm, input logic [7:0] nrx2);
    if ((nrx2 & 8'hF8) != 0) chan_on |= bitm;
    else chan_on &= ~bitm;
    env_lvl[k] = nrx2[3] ? nrx2[7:4] : (4'hF ^ nrx2[7:4]);
    env_cnt[k] = nrx2[2:0];
  endtask

  task automatic env_step(input int k, input logic [7:0] nrx2);
    if (nrx2[2:0] == 0) return;
    if (env_cnt[k] != 0) env_cnt[k]--;
    else begin
      env_cnt[k] = nrx2[2:0];
      if (env_lvl[k] < 15) env_lvl[k]++;
    end
  endtask

  task automatic wave_tick();
    if (period_cnt[2] == 0) begin
      period_cnt[2] = 11'd2047 ^ freq_word(R34, R33);
      wave_pos = wave_pos + 5'd1;
    end else period_cnt[2]--;
  endtask

  task automatic take_read(input logic [15:0] a);
    logic [4:0] r;
    held_valid = 1'b0;
    held_data = '0;
    if (a >= AddrFirst && a <= AddrStatus) begin
      r = reg_of(a);
      held_valid = 1'b1;
      if (a == AddrStatus) held_data = {snd_reg[R52][7], 3'b111, chan_on};
      else if (r == NoReg) held_data = 8'hFF;
      else held_data = snd_reg[r] | rd_mask(a);
    end else if (a >= AddrWave && a <= AddrLast) begin
      held_valid = 1'b1;
      held_data = wave_mem[a[3:0]];
    end
  endtask

  task automatic take_write(input logic [15:0] a, input logic [7:0] d);
    logic [4:0] r;
    logic [10:0] f;
    if (a < AddrFirst || a > AddrLast) return;
    if (!snd_reg[R52][7]) begin
      if (a == AddrStatus) begin
        snd_reg[R52] = d | 8'h70;
        if (d[7]) sound_reset();
      end
      return;
    end
    if (a == AddrNr12) env_write_glitch(0, 4'b0001, snd_reg[R12], d);
    if (a == AddrNr22) env_write_glitch(1, 4'b0010, snd_reg[R22], d);
    if (a == AddrNr42) env_write_glitch(2, 4'b1000, snd_reg[R42], d);
    if (a <= AddrStatus) begin
      r = reg_of(a);
      if (r != NoReg) snd_reg[r] = d | wr_mask(a);
    end
    if (a >= AddrWave) wave_mem[a[3:0]] = d;
    if (!d[7]) return;
    if (a == AddrNr14) begin
      f = freq_word(R14, R13);
      env_start(0, 4'b0001, snd_reg[R12]);
      len_cnt[0] = 9'd64 - snd_reg[R11][5:0];
      sweep_cnt = snd_reg[R10][6:4];
      sweep_freq = f;
      period_cnt[0] = 11'd2047 ^ f;
      duty_pos[0] = '0;
    end else if (a == AddrNr24) begin
      env_start(1, 4'b0010, snd_reg[R22]);
      len_cnt[1] = 9'd64 - snd_reg[R21][5:0];
      period_cnt[1] = 11'd2047 ^ freq_word(R24, R23);
      duty_pos[1] = '0;
    end else if (a == AddrNr34) begin
      if (snd_reg[R32] != 0) chan_on |= 4'b0100;
      else chan_on &= 4'b1011;
      len_cnt[2] = 9'd256 - snd_reg[R31];
      period_cnt[2] = 11'd2047 ^ freq_word(R34, R33);
      wave_pos = '0;
    end else if (a == AddrNr44) begin
      env_start(2, 4'b1000, snd_reg[R42]);
      len_cnt[3] = 9'd64 - snd_reg[R41][5:0];
      period_cnt[3] = noise_div();
      lfsr = 15'h7FFF;
    end
  endtask

  task automatic audio_tick(input logic [13:0] nclk, input logic [13:0] flip);
    logic [2:0]  per, sh;
    logic [10:0] delta;
    logic [11:0] nf;
    logic        fb;
    logic [4:0]  ctl [4];
    logic [3:0]  o1, o2, o3, o4;
    logic [7:0]  b;
    logic [2:0]  vsh;
    logic [5:0]  mr, ml;
    ctl = '{R14, R24, R34, R44};
    o1 = 0; o2 = 0; o3 = 0; o4 = 0; mr = 0; ml = 0;
    if ((nclk & 14'h1FFF) == 14'h1000) begin
      per = snd_reg[R10][6:4];
      sh = snd_reg[R10][2:0];
      if (per != 0 && sh != 0) begin
        if (sweep_cnt != 0) sweep_cnt--;
        else begin
          delta = sweep_freq >> sh;
          nf = snd_reg[R10][3] ? ({1'b0, sweep_freq} - delta) : ({1'b0, sweep_freq} + delta);
          sweep_cnt = per;
          if (nf > 2047) chan_on &= 4'b1110;
          else sweep_freq = nf[10:0];
        end
      end
    end
    if ((nclk & 14'h0FFF) == 0) begin
      for (int i = 0; i < 4; i++) begin
        if (snd_reg[ctl[i]][6] && len_cnt[i] != 0) len_cnt[i]--;
        if (snd_reg[ctl[i]][6] && len_cnt[i] == 0) chan_on[i] = 1'b0;
      end
    end
    if (nclk == 14'h3800) begin
      env_step(0, snd_reg[R12]);
      env_step(1, snd_reg[R22]);
      env_step(2, snd_reg[R42]);
    end
    if (period_cnt[0] == 0) begin
      period_cnt[0] = 11'd2047 ^ ((snd_reg[R10][6:4] != 0) ? sweep_freq : freq_word(R14, R13));
      duty_pos[0]++;
    end else period_cnt[0]--;
    if (period_cnt[1] == 0) begin
      period_cnt[1] = 11'd2047 ^ freq_word(R24, R23);
      duty_pos[1]++;
    end else period_cnt[1]--;
    wave_tick();
    wave_tick();
    if (period_cnt[3] == 0) begin
      fb = lfsr[0] ^ lfsr[1];
      period_cnt[3] = noise_div();
      lfsr = {fb, lfsr[14:1]};
      if (snd_reg[R43][3]) lfsr[6] = fb;
    end else begin
      period_cnt[3] = period_cnt[3] - ((snd_reg[R43][7:4] > 13) ? 11'd0
                                       : 11'(flip[snd_reg[R43][7:4]]));
    end
    if (chan_on[0]) o1 = duty_out(0, snd_reg[R11], env_vol(0, snd_reg[R12]));
    if (chan_on[1]) o2 = duty_out(1, snd_reg[R21], env_vol(1, snd_reg[R22]));
    if (chan_on[2] && snd_reg[R30][7]) begin
      b = wave_mem[wave_pos[4:1]];
      b = wave_pos[0] ? {4'd0, b[3:0]} : {4'd0, b[7:4]};
      case (snd_reg[R32][6:5])
        0: vsh = 4; 1: vsh = 0; 2: vsh = 1; default: vsh = 2;
      endcase
      o3 = 4'(b >> vsh);
    end
    if (chan_on[3]) o4 = lfsr[0] ? env_vol(2, snd_reg[R42]) : 4'd0;
    if (snd_reg[R51][0]) mr += o1;
    if (snd_reg[R51][1]) mr += o2;
    if (snd_reg[R51][2]) mr += o3;
    if (snd_reg[R51][3]) mr += o4;
    if (snd_reg[R51][4]) ml += o1;
    if (snd_reg[R51][5]) ml += o2;
    if (snd_reg[R51][6]) ml += o3;
    if (snd_reg[R51][7]) ml += o4;
    held_right = 9'({3'b000, mr} * ({6'd0, snd_reg[R50][2:0]} + 9'd1));
    held_left = 9'({3'b000, ml} * ({6'd0, snd_reg[R50][6:4]} + 9'd1));
  endtask

  task automatic sound_predict(input bus_item_t it, output sound_out_t res);
    logic        on;
    logic [13:0] nclk, flip;
    on = snd_reg[R52][7];
    nclk = frame_cnt + 14'd1;
    flip = ~frame_cnt & nclk;
    if (it.phase == PhaseAudio && it.command == CmdRead) take_read(it.address);
    if (it.phase == PhaseWrite && it.command == CmdWrite) take_write(it.address, it.write_data);
    if (it.phase == PhaseAudio) begin
      if (!on) begin
        held_right = '0;
        held_left = '0;
      end else begin
        audio_tick(nclk, flip);
        frame_cnt = nclk;
      end
    end
    res = '{held_valid, held_data, held_right, held_left};
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender side.
  task automatic send_item(input bus_item_t it, input logic known, input sound_out_t want);
    sound_out_t exp_res;
    in_ch.valid <= 1'b1;
    {in_ch.phase, in_ch.command, in_ch.address, in_ch.write_data} <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sound_predict(it, exp_res);
    expected_q.push_back(exp_res);
    known_q.push_back(known);
    known_want_q.push_back(want);
    items_sent++;
    if ($urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic bus_item_t mk(input logic [1:0] ph, input logic [1:0] cmd,
                                   input logic [15:0] a, input logic [7:0] d);
    return '{ph, cmd, a, d};
  endfunction

  function automatic bus_item_t random_item();
    bus_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.write_data = 8'($urandom);
    if (sel < 3) it.address = 16'($urandom);
    else if (sel < 8) it.address = AddrStatus;
    else if (sel < 20) it.address = 16'(AddrNr14 + 5 * $urandom_range(0, 3) - (sel & 1));
    else if (sel < 40) it.address = 16'(AddrWave + $urandom_range(0, 15));
    else it.address = 16'(AddrFirst + $urandom_range(0, 22));
    it.command = 2'($urandom_range(0, 3));
    if (it.command == CmdWrite && $urandom_range(0, 3) != 0) it.phase = PhaseWrite;
    else if (it.command != CmdWrite && $urandom_range(0, 3) != 0) it.phase = PhaseAudio;
    else it.phase = 2'($urandom_range(0, 3));
    if (it.address == AddrStatus && it.command == CmdWrite && $urandom_range(0, 3) != 0)
      it.write_data[7] = 1'b1;
    return it;
  endfunction

  initial begin
    row_t rows [$];
    sound_out_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.phase = '0;
    in_ch.command = '0;
    in_ch.address = '0;
    in_ch.write_data = '0;
    items_sent = 0;
    stim_done = 0;
    sound_reset();
    rows.push_back('{mk(PhaseAudio, CmdRead, AddrStatus, 8'h00), 1'b1,
                     '{1'b1, 8'hF1, 9'd120, 9'd120}});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFF15, 8'h00), 1'b1,
                     '{1'b1, 8'hFF, 9'd120, 9'd120}});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'h0000, 8'h00), 1'b1,
                     '{1'b0, 8'h00, 9'd120, 9'd120}});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFFFF, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFF1F, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFF27, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF30, 8'hFF), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF3F, 8'hA5), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFF3F, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, 2'd3, 16'hFF3F, 8'h00), 1'b0, none});
    rows.push_back('{mk(2'd1, CmdRead, AddrStatus, 8'h00), 1'b0, none});
    rows.push_back('{mk(2'd3, CmdWrite, 16'hFF24, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF25, 8'hFF), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF24, 8'h77), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrNr12, 8'h08), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrNr12, 8'hF9), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrNr14, 8'hC7), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF22, 8'h08), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrNr42, 8'hF0), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrNr44, 8'h80), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, CmdNone, 16'h0000, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrStatus, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, 16'hFF24, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseAudio, CmdRead, 16'hFF24, 8'h00), 1'b0, none});
    rows.push_back('{mk(PhaseWrite, CmdWrite, AddrStatus, 8'h80), 1'b0, none});
    @(posedge clk_i iff rst_ni);
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].want);
    for (int n = 0; n < 1400; n++) begin
      if (n == 400) long_hold = 1'b1;
      send_item(random_item(), 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver side, with one long hold-off so the block backs up.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    long_hold = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 200) begin
          @(posedge clk_i);
          hold++;
        end
      end
      out_ch.ready <= ($urandom_range(0, 9) < 7) || (results_seen % 300 < 60);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sound_out_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.reply_valid, out_ch.reply_data, out_ch.mix_right, out_ch.mix_left};
      results_seen++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (known_q.pop_front() && known_want_q[0] != want) begin
          if (mismatches < 10) $display("predictor off on directed row: %p vs %p",
                                        want, known_want_q[0]);
          mismatches++;
        end
        void'(known_want_q.pop_front());
        if (got !== want) begin
          if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int idle;
    mismatches = 0;
    results_seen = 0;
    idle = 0;
    @(posedge clk_i iff rst_ni);
    while (!(stim_done && expected_q.size() == 0) && idle < 2000) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    repeat (10) @(posedge clk_i);
    if (idle >= 2000) begin
      $display("simulation failed");
    end else begin
      $display("Sent %0d bus transfers and checked %0d results; %0d mismatches.",
               items_sent, results_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule
